FILE: rtl/matrix_ring_rotate_defines.svh
// Assertion macros used by the matrix ring rotate RTL.
`ifndef MATRIX_RING_ROTATE_DEFINES_SVH
`define MATRIX_RING_ROTATE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define MRR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define MRR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/mrr_pkg.sv
// Package with types and constants of the matrix ring rotate block.
`default_nettype none

package mrr_pkg;

    localparam int MAX_DIM_DEFAULT = 16;

    localparam int DIM_W     = 5;
    localparam int POS_W     = 4;
    localparam int VALUE_W   = 32;
    localparam int CFG_IDX_W = 2;

    typedef logic [DIM_W-1:0]     dim_t;
    typedef logic [POS_W-1:0]     pos_t;
    typedef logic [VALUE_W-1:0]   word_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam dim_t ROWS_RESET = dim_t'(16);
    localparam dim_t COLS_RESET = dim_t'(16);

    localparam cfg_idx_t CFG_ROWS = cfg_idx_t'(0);
    localparam cfg_idx_t CFG_COLS = cfg_idx_t'(1);

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_READ  = 1'b1;

endpackage

`default_nettype wire

FILE: rtl/mrr_addr.sv
// Ring source address unit: maps a position to the word it shows after rotation.
`default_nettype none

module mrr_addr #(
    parameter int MAX_DIM = mrr_pkg::MAX_DIM_DEFAULT
) (
    input  mrr_pkg::dim_t rows,
    input  mrr_pkg::dim_t cols,
    input  mrr_pkg::pos_t row_index,
    input  mrr_pkg::pos_t col_index,
    output logic          in_range,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] plain_addr,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] addr
);
    import mrr_pkg::*;

    localparam int MAX_W = $clog2(MAX_DIM + 1);
    localparam int DW    = (MAX_W > DIM_W) ? MAX_W : DIM_W;
    localparam int AW    = $clog2(MAX_DIM * MAX_DIM);
    localparam int PW    = AW + DW;
    localparam logic [DW-1:0] MAX_D = DW'(MAX_DIM);
    localparam logic [DW-1:0] ONE_D = DW'(1);

    logic [DW-1:0] nr, nc, r, c;
    logic [DW-1:0] dist_b, dist_r, k, half;
    logic [DW-1:0] bottom, right;
    logic [DW-1:0] src_r, src_c;

    always_comb
    begin
        // Zero acts as one, anything above the store size acts as the store size.
        if (rows == '0)
            nr = ONE_D;
        else if (DW'(rows) > MAX_D)
            nr = MAX_D;
        else
            nr = DW'(rows);
        if (cols == '0)
            nc = ONE_D;
        else if (DW'(cols) > MAX_D)
            nc = MAX_D;
        else
            nc = DW'(cols);

        r = DW'(row_index);
        c = DW'(col_index);
        in_range = (r < nr) && (c < nc);

        // Ring index is the distance to the nearest edge.
        dist_b = nr - ONE_D - r;
        dist_r = nc - ONE_D - c;
        k = (r < c) ? r : c;
        if (dist_b < k)
            k = dist_b;
        if (dist_r < k)
            k = dist_r;
        half   = ((nr < nc) ? nr : nc) >> 1;
        bottom = nr - ONE_D - k;
        right  = nc - ONE_D - k;

        src_r = r;
        src_c = c;
        if (k < half)
        begin
            if (r == k && c > k)
                src_c = c - ONE_D;
            else if (c == right && r > k)
                src_r = r - ONE_D;
            else if (r == bottom && c < right)
                src_c = c + ONE_D;
            else
                src_r = r + ONE_D;
        end

        plain_addr = AW'(PW'(r) * PW'(MAX_DIM) + PW'(c));
        addr       = AW'(PW'(src_r) * PW'(MAX_DIM) + PW'(src_c));
    end

endmodule

`default_nettype wire

FILE: rtl/matrix_ring_rotate.sv
// Top level of the matrix ring rotate block: register file, word memory, result stage.
//
//   channel   direction  handshake                 payload
//   request   in         start && !busy            kind, row_index, col_index, value
//   result    out        result_valid (one cycle)  rotated_value
//   config    in         cfg_valid && cfg_ready    cfg_index, cfg_data
//
// One request is taken every cycle; busy stays low.
// A read request shows its result in the cycle right after it is taken, the
// latency of the single-port word memory; write requests give no result.
// Reset sets rows and cols to 16; memory contents are undefined until written.
// The result cannot be stalled: result_valid is high for exactly one cycle.
`default_nettype none
`include "matrix_ring_rotate_defines.svh"

module matrix_ring_rotate #(
    parameter int MAX_DIM = mrr_pkg::MAX_DIM_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              kind,
    input  mrr_pkg::pos_t     row_index,
    input  mrr_pkg::pos_t     col_index,
    input  mrr_pkg::word_t    value,
    output logic              result_valid,
    output mrr_pkg::word_t    rotated_value,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  mrr_pkg::cfg_idx_t cfg_index,
    input  mrr_pkg::dim_t     cfg_data
);
    import mrr_pkg::*;

    localparam int AW    = $clog2(MAX_DIM * MAX_DIM);
    localparam int DEPTH = MAX_DIM * MAX_DIM;

    dim_t  rows_reg, rows_next;
    dim_t  cols_reg, cols_next;
    logic  result_valid_reg;
    logic  in_range_reg;
    word_t mem_q_reg;
    word_t mem [DEPTH];

    logic          req;
    logic          rd_req;
    logic          wr_req;
    logic          in_range;
    logic [AW-1:0] plain_addr;
    logic [AW-1:0] addr;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign req       = start && !busy;
    assign rd_req    = req && kind == KIND_READ;
    assign wr_req    = req && kind == KIND_WRITE;

    always_comb
    begin
        rows_next = rows_reg;
        cols_next = cols_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ROWS: rows_next = cfg_data;
                CFG_COLS: cols_next = cfg_data;
                default:  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= ROWS_RESET;
            cols_reg <= COLS_RESET;
        end
        else
        begin
            rows_reg <= rows_next;
            cols_reg <= cols_next;
        end
    end

    mrr_addr #(
        .MAX_DIM (MAX_DIM)
    ) u_addr (
        .rows       (rows_reg),
        .cols       (cols_reg),
        .row_index  (row_index),
        .col_index  (col_index),
        .in_range   (in_range),
        .plain_addr (plain_addr),
        .addr       (addr)
    );

    // A write stores at the plain position; a read fetches the ring source word.
    always_ff @(posedge clk)
    begin
        if (wr_req && in_range)
            mem[plain_addr] <= value;
        if (rd_req)
            mem_q_reg <= mem[addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            in_range_reg     <= 1'b0;
        end
        else
        begin
            result_valid_reg <= rd_req;
            if (rd_req)
                in_range_reg <= in_range;
        end
    end

    assign result_valid  = result_valid_reg;
    assign rotated_value = in_range_reg ? mem_q_reg : '0;

    `MRR_ASSERT_NEXT(a_read_gives_result, clk, rst_n, rd_req, result_valid, "read gave no result")
    `MRR_ASSERT_NEXT(a_write_gives_none, clk, rst_n, wr_req, !result_valid, "write gave a result")
    `MRR_ASSERT_NOW(a_result_has_cause, clk, rst_n, result_valid, $past(rd_req), "result without read")

endmodule

`default_nettype wire

FILE: tb/sv/matrix_ring_rotate_tb.sv
// Self-checking testbench for matrix_ring_rotate: ring rotation reads against a shadow matrix.
module matrix_ring_rotate_tb;
    import mrr_pkg::*;

    localparam int DIM = MAX_DIM_DEFAULT;
    localparam int SHAPES = 10;
    localparam int ITEMS_PER_SHAPE = 80;

    // Register indexes that the block must ignore.
    localparam cfg_idx_t CFG_SPARE_A = cfg_idx_t'(2);
    localparam cfg_idx_t CFG_SPARE_B = cfg_idx_t'(3);

    typedef enum logic [1:0] {STEP_WRITE, STEP_READ, STEP_CONFIG} step_op_t;

    typedef struct {
        step_op_t op;
        cfg_idx_t idx;
        pos_t     r;
        pos_t     c;
        word_t    data;
        bit       typed;
        word_t    want;
    } step_t;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    logic     kind;
    pos_t     row_index;
    pos_t     col_index;
    word_t    value;
    logic     result_valid;
    word_t    rotated_value;
    logic     cfg_valid;
    logic     cfg_ready;
    cfg_idx_t cfg_index;
    dim_t     cfg_data;

    // Shadow of the block: matrix contents, which entries hold data, and the shape in use.
    word_t mem_shadow [DIM*DIM];
    bit    mem_written [DIM*DIM];
    dim_t  rows_cfg;
    dim_t  cols_cfg;

    word_t expected_words [$];
    step_t directed_steps [$];

    dim_t shape_rows [SHAPES] = '{16, 1, 31, 2, 3, 16, 1, 5, 0, 9};
    dim_t shape_cols [SHAPES] = '{16, 1, 0, 2, 7, 1, 16, 5, 31, 13};

    int idle_pct;
    int fail_count;
    int reads_sent;
    int writes_sent;
    int results_checked;
    int cfg_writes;

    matrix_ring_rotate dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .kind          (kind),
        .row_index     (row_index),
        .col_index     (col_index),
        .value         (value),
        .result_valid  (result_valid),
        .rotated_value (rotated_value),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(12 * 100000);
        $display("** matrix_ring_rotate: FAILED **");
        $finish;
    end

    function automatic int unsigned dim_in_use(dim_t d);
        if (d == 0)
            return 1;
        if (d > DIM)
            return DIM;
        return d;
    endfunction

    // Address of the stored word that lands on (r, c) once every full ring has
    // turned clockwise by one. The position must lie inside the matrix.
    function automatic int unsigned rotation_source(int unsigned r, int unsigned c);
        int unsigned nr;
        int unsigned nc;
        int unsigned k;
        int unsigned k2;
        nr = dim_in_use(rows_cfg);
        nc = dim_in_use(cols_cfg);
        k  = (r < c) ? r : c;
        k2 = ((nr - 1 - r) < (nc - 1 - c)) ? (nr - 1 - r) : (nc - 1 - c);
        k  = (k < k2) ? k : k2;
        if (k >= ((nr < nc) ? nr : nc) / 2)
            return r * DIM + c;
        if (r == k && c > k)
            return r * DIM + c - 1;
        if (c == nc - 1 - k && r > k)
            return (r - 1) * DIM + c;
        if (r == nr - 1 - k && c < nc - 1 - k)
            return r * DIM + c + 1;
        return (r + 1) * DIM + c;
    endfunction

    function automatic void add_step(step_op_t op, cfg_idx_t idx, pos_t r, pos_t c,
                                     word_t data, bit typed, word_t want);
        step_t st;
        st.op    = op;
        st.idx   = idx;
        st.r     = r;
        st.c     = c;
        st.data  = data;
        st.typed = typed;
        st.want  = want;
        directed_steps.push_back(st);
    endfunction

    // Drives one request, waits for it to be taken, then updates the shadow
    // matrix or queues the word the read must return.
    task automatic issue_request(logic k, pos_t r, pos_t c, word_t v, bit typed, word_t want);
        int unsigned addr;
        bit          in_bounds;
        start     <= 1'b1;
        kind      <= k;
        row_index <= r;
        col_index <= c;
        value     <= v;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        addr      = r * DIM + c;
        in_bounds = (r < dim_in_use(rows_cfg)) && (c < dim_in_use(cols_cfg));
        if (k == KIND_WRITE)
        begin
            writes_sent++;
            if (in_bounds)
            begin
                mem_shadow[addr]  = v;
                mem_written[addr] = 1'b1;
            end
        end
        else
        begin
            reads_sent++;
            if (typed)
                expected_words.push_back(want);
            else if (!in_bounds)
                expected_words.push_back('0);
            else
                expected_words.push_back(mem_shadow[rotation_source(r, c)]);
        end
        // Each cycle stays idle with the chosen percentage.
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Leaves cfg_valid high; the caller lowers it after the last register.
    task automatic write_reg(cfg_idx_t idx, dim_t d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_writes++;
        if (idx == CFG_ROWS)
            rows_cfg = d;
        else if (idx == CFG_COLS)
            cols_cfg = d;
    endtask

    // Writes give no result, so the wait does not end as soon as the last read returns.
    task automatic wait_for_drain();
        start <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid === 1'b1)
        begin
            if (expected_words.size() == 0)
            begin
                $error("rotated_value: result with no read request waiting, actual %h",
                       rotated_value);
                fail_count++;
            end
            else
            begin
                if (rotated_value !== expected_words[0])
                begin
                    $error("rotated_value mismatch: expected %h, actual %h",
                           expected_words[0], rotated_value);
                    fail_count++;
                end
                void'(expected_words.pop_front());
                results_checked++;
            end
        end
    end

    initial
    begin
        step_t       st;
        int unsigned nr;
        int unsigned nc;
        int unsigned src;
        logic        k;
        pos_t        r;
        pos_t        c;
        word_t       v;

        rst_n     = 1'b0;
        start     = 1'b0;
        kind      = KIND_WRITE;
        row_index = '0;
        col_index = '0;
        value     = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_ROWS;
        cfg_data  = '0;
        rows_cfg  = ROWS_RESET;
        cols_cfg  = COLS_RESET;
        idle_pct  = 26;
        fail_count      = 0;
        reads_sent      = 0;
        writes_sent     = 0;
        results_checked = 0;
        cfg_writes      = 0;
        for (int i = 0; i < DIM * DIM; i++)
        begin
            mem_shadow[i]  = '0;
            mem_written[i] = 1'b0;
        end
        shape_rows[SHAPES-1] = dim_t'($urandom_range(0, 31));
        shape_cols[SHAPES-1] = dim_t'($urandom_range(0, 31));

        // Reset shape 16x16: one element of each edge of the outer ring,
        // then the whole innermost ring, with extreme words.
        add_step(STEP_WRITE, CFG_ROWS, 0, 0, 32'h7FFF_FFFF, 0, 0);
        add_step(STEP_WRITE, CFG_ROWS, 0, 1, 32'h8000_0000, 0, 0);
        add_step(STEP_READ,  CFG_ROWS, 0, 1, 0, 1, 32'h7FFF_FFFF);
        add_step(STEP_WRITE, CFG_ROWS, 15, 15, 32'hFFFF_FFFF, 0, 0);
        add_step(STEP_WRITE, CFG_ROWS, 14, 15, 32'h0000_0000, 0, 0);
        add_step(STEP_READ,  CFG_ROWS, 15, 15, 0, 1, 32'h0000_0000);
        add_step(STEP_WRITE, CFG_ROWS, 1, 0, 32'hAAAA_5555, 0, 0);
        add_step(STEP_READ,  CFG_ROWS, 0, 0, 0, 1, 32'hAAAA_5555);
        add_step(STEP_READ,  CFG_ROWS, 15, 14, 0, 1, 32'hFFFF_FFFF);
        add_step(STEP_WRITE, CFG_ROWS, 7, 7, 32'h1111_1111, 0, 0);
        add_step(STEP_WRITE, CFG_ROWS, 7, 8, 32'h2222_2222, 0, 0);
        add_step(STEP_WRITE, CFG_ROWS, 8, 8, 32'h3333_3333, 0, 0);
        add_step(STEP_WRITE, CFG_ROWS, 8, 7, 32'h55AA_55AA, 0, 0);
        add_step(STEP_READ,  CFG_ROWS, 7, 8, 0, 1, 32'h1111_1111);
        add_step(STEP_READ,  CFG_ROWS, 8, 8, 0, 1, 32'h2222_2222);
        add_step(STEP_READ,  CFG_ROWS, 8, 7, 0, 1, 32'h3333_3333);
        add_step(STEP_READ,  CFG_ROWS, 7, 7, 0, 1, 32'h55AA_55AA);
        // 3x5: the middle row is a centre line, and positions outside read as zero.
        add_step(STEP_CONFIG, CFG_ROWS, 0, 0, 3, 0, 0);
        add_step(STEP_CONFIG, CFG_COLS, 0, 0, 5, 0, 0);
        add_step(STEP_WRITE, CFG_ROWS, 1, 2, 32'h0000_1234, 0, 0);
        add_step(STEP_READ,  CFG_ROWS, 1, 2, 0, 1, 32'h0000_1234);
        add_step(STEP_READ,  CFG_ROWS, 3, 0, 0, 1, 32'h0000_0000);
        add_step(STEP_WRITE, CFG_ROWS, 0, 7, 32'hDEAD_BEEF, 0, 0);
        add_step(STEP_READ,  CFG_ROWS, 4, 9, 0, 1, 32'h0000_0000);
        add_step(STEP_READ,  CFG_ROWS, 0, 1, 0, 0, 0);
        // An unknown index is ignored; zero rows act as one and 31 columns as 16,
        // so the single row forms no ring.
        add_step(STEP_CONFIG, CFG_SPARE_A, 0, 0, 31, 0, 0);
        add_step(STEP_CONFIG, CFG_ROWS, 0, 0, 0, 0, 0);
        add_step(STEP_CONFIG, CFG_COLS, 0, 0, 31, 0, 0);
        add_step(STEP_READ,  CFG_ROWS, 0, 1, 0, 1, 32'h8000_0000);
        add_step(STEP_READ,  CFG_ROWS, 1, 0, 0, 1, 32'h0000_0000);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < directed_steps.size(); i++)
        begin
            st = directed_steps[i];
            if (st.op == STEP_CONFIG)
            begin
                if (i == 0 || directed_steps[i-1].op != STEP_CONFIG)
                    wait_for_drain();
                write_reg(st.idx, dim_t'(st.data));
                if (i + 1 == directed_steps.size() || directed_steps[i+1].op != STEP_CONFIG)
                    cfg_valid <= 1'b0;
            end
            else
            begin
                issue_request((st.op == STEP_READ) ? KIND_READ : KIND_WRITE,
                              st.r, st.c, st.data, st.typed, st.want);
            end
        end

        for (int shape = 0; shape < SHAPES; shape++)
        begin
            idle_pct = (shape < 4) ? 26 : (shape < 7) ? 59 : 0;
            wait_for_drain();
            if (shape == 5)
                write_reg(CFG_SPARE_B, dim_t'(5'h15));
            write_reg(CFG_ROWS, shape_rows[shape]);
            write_reg(CFG_COLS, shape_cols[shape]);
            cfg_valid <= 1'b0;
            nr = dim_in_use(rows_cfg);
            nc = dim_in_use(cols_cfg);
            for (int n = 0; n < ITEMS_PER_SHAPE; n++)
            begin
                k = ($urandom_range(0, 1) == 0) ? KIND_WRITE : KIND_READ;
                r = ($urandom_range(0, 9) == 0) ? pos_t'($urandom_range(0, 15))
                                                : pos_t'($urandom_range(0, nr - 1));
                c = ($urandom_range(0, 9) == 0) ? pos_t'($urandom_range(0, 15))
                                                : pos_t'($urandom_range(0, nc - 1));
                case ($urandom_range(0, 15))
                    0:       v = 32'h8000_0000;
                    1:       v = 32'h7FFF_FFFF;
                    2:       v = 32'h0000_0000;
                    3:       v = 32'hFFFF_FFFF;
                    default: v = $urandom;
                endcase
                // A read whose source was never written becomes a write of that source.
                if (k == KIND_READ && r < nr && c < nc)
                begin
                    src = rotation_source(r, c);
                    if (!mem_written[src])
                    begin
                        k = KIND_WRITE;
                        r = pos_t'(src / DIM);
                        c = pos_t'(src % DIM);
                    end
                end
                issue_request(k, r, c, v, 1'b0, '0);
            end
        end

        wait_for_drain();
        $display("Covered %0d write and %0d read requests, %0d results checked,",
                 writes_sent, reads_sent, results_checked);
        $display("over %0d register writes and %0d random matrix shapes with and without gaps.",
                 cfg_writes, SHAPES);
        if (fail_count == 0)
            $display("** matrix_ring_rotate: PASSED **");
        else
            $display("** matrix_ring_rotate: FAILED **");
        $finish;
    end

endmodule
